### sv/imhq_pkg.sv
// ---------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants of the indexed min-heap queue.
// ---------------------------------------------------------------------------
package imhq_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int VTX_W     = 8;
  localparam int VTX_N     = 1 << VTX_W;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_DECREASE = 3'd1;
  localparam logic [2:0] CMD_EXTRACT  = 3'd2;
  localparam logic [2:0] CMD_PEEK     = 3'd3;
  localparam logic [2:0] CMD_REMOVE   = 3'd4;
  localparam logic [2:0] CMD_LOOKUP   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;
  localparam logic [2:0] ST_KEY_INC  = 3'd5;
  localparam logic [2:0] ST_BAD_POS  = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  vertex;
    logic [31:0] key;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_vertex;
    logic [31:0] out_key;
    logic [8:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]     vtx;
    logic [KEY_WIDTH-1:0] key;
  } heap_ent_t;

endpackage

### sv/imhq_ram.sv
// ---------------------------------------------------------------------------
// imhq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/imhq_ctrl.sv
// ---------------------------------------------------------------------------
// imhq_ctrl
// Command sequencer: owns the heap and vertex-map RAMs, presence bits and
// the entry count, and walks sift-up / sift-down one level at a time.
// ---------------------------------------------------------------------------
module imhq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  imhq_pkg::in_item_t   in_data,
  output logic                 busy,
  input  logic                 out_free,
  output logic                 done,
  output imhq_pkg::out_item_t  res
);
  import imhq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC_MAP, S_DEC_HEAP, S_REM_RD, S_REM_LAST, S_LK_MAP, S_RD_OUT,
    S_UP, S_UP_CMP, S_DOWN, S_DN_L, S_DN_R, S_DN_DEC, S_DONE
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    total_r;
  logic [SLOT_W-1:0]   pos_r;
  logic [VTX_N-1:0]    present_r;
  heap_ent_t           item_r;
  heap_ent_t           best_r;
  logic                best_vld_r;
  logic [SLOT_W-1:0]   best_pos_r;
  logic                fb_r;        // fall back to sift-down if no upward move
  out_item_t           res_r;

  logic                h_we, m_we;
  logic [SLOT_W-1:0]   h_waddr, h_raddr, m_wdata;
  logic [VTX_W-1:0]    m_waddr, m_raddr;
  heap_ent_t           h_wdata, h_rdata;
  logic [SLOT_W-1:0]   m_rdata;

  logic [SLOT_W-1:0]   par;
  logic [SLOT_W+1:0]   l_idx, r_idx;
  logic                l_in, r_in, up_less, dn_l_less, dn_r_less, vin;
  logic [KEY_WIDTH-1:0] cmp_key, in_key;
  logic [CNT_W-1:0]    total_dec;

  // decision for a command taken in idle
  state_t              acc_state;
  logic [2:0]          acc_status;
  logic                acc_ins;

  assign par       = SLOT_W'((pos_r - 1'b1) >> 1);
  assign l_idx     = {1'b0, pos_r, 1'b1};
  assign r_idx     = l_idx + 1'b1;
  assign l_in      = l_idx < (SLOT_W+2)'(total_r);
  assign r_in      = r_idx < (SLOT_W+2)'(total_r);
  assign up_less   = item_r.key < h_rdata.key;
  assign dn_l_less = h_rdata.key < item_r.key;
  assign cmp_key   = best_vld_r ? best_r.key : item_r.key;
  assign dn_r_less = h_rdata.key < cmp_key;
  assign vin       = 32'(in_data.vertex) < CAPACITY;
  assign in_key    = KEY_WIDTH'(in_data.key);
  assign total_dec = total_r - 1'b1;

  assign busy = state_r != S_IDLE;
  assign done = (state_r == S_DONE) && out_free;
  assign res  = res_r;

  imhq_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CAPACITY)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  imhq_ram #(.WIDTH(SLOT_W), .DEPTH(VTX_N)) u_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  always_comb begin
    acc_state  = S_DONE;
    acc_status = ST_OK;
    acc_ins    = 1'b0;
    unique case (in_data.command)
      CMD_INSERT: begin
        if (total_r == CNT_W'(CAPACITY)) begin
          acc_status = ST_FULL;
        end else if (!vin) begin
          acc_status = ST_ABSENT;
        end else if (present_r[in_data.vertex]) begin
          acc_status = ST_DUP;
        end else begin
          acc_ins   = 1'b1;
          acc_state = S_UP;
        end
      end
      CMD_DECREASE, CMD_LOOKUP: begin
        if (!vin || !present_r[in_data.vertex]) begin
          acc_status = ST_ABSENT;
        end else begin
          acc_state = (in_data.command == CMD_LOOKUP) ? S_LK_MAP : S_DEC_MAP;
        end
      end
      CMD_EXTRACT, CMD_REMOVE: begin
        if (total_r == '0) begin
          acc_status = ST_EMPTY;
        end else if (in_data.command == CMD_REMOVE &&
                     32'(in_data.position) >= 32'(total_r)) begin
          acc_status = ST_BAD_POS;
        end else begin
          acc_state = S_REM_RD;
        end
      end
      CMD_PEEK: begin
        if (total_r == '0) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_state = S_RD_OUT;
        end
      end
      default: acc_status = ST_BAD_POS;
    endcase
  end

  // memory port control
  always_comb begin
    h_we    = 1'b0;
    h_waddr = pos_r;
    h_wdata = item_r;
    h_raddr = pos_r;
    m_we    = 1'b0;
    m_waddr = item_r.vtx;
    m_wdata = pos_r;
    m_raddr = in_data.vertex;
    unique case (state_r)
      S_IDLE: begin
        if (in_data.command == CMD_EXTRACT || in_data.command == CMD_PEEK) begin
          h_raddr = '0;
        end else begin
          h_raddr = SLOT_W'(in_data.position);
        end
      end
      S_DEC_MAP, S_LK_MAP: h_raddr = m_rdata;
      S_REM_RD:            h_raddr = SLOT_W'(total_dec);
      S_UP: begin
        h_raddr = par;
        if (pos_r == '0 && !fb_r) begin
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        if (up_less) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          m_we    = 1'b1;
          m_waddr = h_rdata.vtx;
        end else if (!fb_r) begin
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_DOWN: begin
        h_raddr = l_idx[SLOT_W-1:0];
        if (!l_in) begin
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_DN_L: h_raddr = r_idx[SLOT_W-1:0];
      S_DN_DEC: begin
        h_we = 1'b1;
        m_we = 1'b1;
        if (best_vld_r) begin
          h_wdata = best_r;
          m_waddr = best_r.vtx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      present_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            res_r.status       <= acc_status;
            res_r.out_vertex   <= '0;
            res_r.out_key      <= '0;
            res_r.entry_count  <= acc_ins ? 9'(total_r + 1'b1) : 9'(total_r);
            item_r.vtx         <= in_data.vertex;
            item_r.key         <= in_key;
            fb_r               <= 1'b0;
            state_r            <= acc_state;
            if (acc_ins) begin
              present_r[in_data.vertex] <= 1'b1;
              total_r                   <= total_r + 1'b1;
            end
            if (acc_ins) begin
              pos_r <= SLOT_W'(total_r);
            end else if (in_data.command == CMD_REMOVE) begin
              pos_r <= SLOT_W'(in_data.position);
            end else begin
              pos_r <= '0;
            end
          end
        end
        S_DEC_MAP: begin
          pos_r   <= m_rdata;
          state_r <= S_DEC_HEAP;
        end
        S_DEC_HEAP: begin
          if (item_r.key > h_rdata.key) begin
            res_r.status <= ST_KEY_INC;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_UP;
          end
        end
        S_LK_MAP: state_r <= S_RD_OUT;
        S_RD_OUT: begin
          res_r.out_vertex <= h_rdata.vtx;
          res_r.out_key    <= 32'(h_rdata.key);
          state_r          <= S_DONE;
        end
        S_REM_RD: begin
          res_r.out_vertex         <= h_rdata.vtx;
          res_r.out_key            <= 32'(h_rdata.key);
          res_r.entry_count        <= 9'(total_dec);
          present_r[h_rdata.vtx]   <= 1'b0;
          total_r                  <= total_dec;
          state_r <= (CNT_W'(pos_r) == total_dec) ? S_DONE : S_REM_LAST;
        end
        S_REM_LAST: begin
          item_r  <= h_rdata;
          fb_r    <= 1'b1;
          state_r <= S_UP;
        end
        S_UP: begin
          if (pos_r == '0) begin
            state_r <= fb_r ? S_DOWN : S_DONE;
          end else begin
            state_r <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_less) begin
            pos_r   <= par;
            fb_r    <= 1'b0;
            state_r <= S_UP;
          end else begin
            state_r <= fb_r ? S_DOWN : S_DONE;
          end
        end
        S_DOWN: begin
          best_vld_r <= 1'b0;
          state_r    <= l_in ? S_DN_L : S_DONE;
        end
        S_DN_L: begin
          if (dn_l_less) begin
            best_vld_r <= 1'b1;
            best_r     <= h_rdata;
            best_pos_r <= l_idx[SLOT_W-1:0];
          end
          state_r <= r_in ? S_DN_R : S_DN_DEC;
        end
        S_DN_R: begin
          if (dn_r_less) begin
            best_vld_r <= 1'b1;
            best_r     <= h_rdata;
            best_pos_r <= r_idx[SLOT_W-1:0];
          end
          state_r <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (best_vld_r) begin
            pos_r   <= best_pos_r;
            state_r <= S_DOWN;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/indexed_min_heap_queue_top.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap with vertex-to-slot map and six commands.
// ---------------------------------------------------------------------------
// One command is in flight at a time and every command returns exactly one
// result. Inserts and decreases sift up and removals re-sift the moved
// entry, one level at a time. The pace is set by the single read port of
// the heap RAM: each parent or child read is issued in one state and used
// in the next. Results sit in an output register, so the next command may
// enter while the previous result waits to be taken.
module indexed_min_heap_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  imhq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output imhq_pkg::out_item_t out_data
);
  import imhq_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free, done;
  out_item_t res;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  imhq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_data, .busy(in_stall), .out_free, .done, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

endmodule

### sv/imhq_checker.sv
// ---------------------------------------------------------------------------
// imhq_checker
// Port-level checks of the indexed min-heap queue.
// ---------------------------------------------------------------------------
module imhq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input imhq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input imhq_pkg::out_item_t out_data
);
  import imhq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // one transaction at a time: busy right after taking a command
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while another in flight");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.entry_count) <= CAPACITY)
    else $error("entry count beyond capacity");

endmodule

bind indexed_min_heap_queue_top imhq_checker u_imhq_checker (.*);
